// File: src/cosine_similarity_engine_macros.svh
// ----------------------------------------------------------------------------
// cosine_similarity_engine_macros.svh
// Assertion macros shared by the cosine similarity engine modules.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// Checked on every clock edge outside reset.
`define CSIM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define CSIM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: src/csim_pkg.sv
// ----------------------------------------------------------------------------
// csim_pkg
// Widths, constants and types of the cosine similarity engine.
// ----------------------------------------------------------------------------
package csim_pkg;

    // element width default
    localparam int ELEM_WIDTH_DEF = 16;

    // accumulator widths (sums of Q2.30 products)
    localparam int DOT_W = 41;
    localparam int SQ_W  = 40;

    // result
    localparam int RES_W  = 16;
    localparam int Q_BITS = 16;
    localparam logic [Q_BITS-1:0] CAP_POS = 16'd32767;
    localparam logic [Q_BITS-1:0] CAP_NEG = 16'd32768;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = 1;
    localparam int CNT_W      = 2;

    // multi-cycle multiplier: 41-bit operands split into 21 + 20 bit halves
    localparam int MAG_W    = 41;
    localparam int MUL_HALF = 21;
    localparam int PP_W     = 2 * MUL_HALF;
    localparam int ACC_W    = 81;

    // root search widths
    localparam int P_W        = 80;   // sumA * sumB
    localparam int R_W        = 81;   // dot * dot
    localparam int ROOT_SHIFT = 30;
    localparam int E_W        = R_W + ROOT_SHIFT;   // remainder
    localparam int M_W        = P_W + Q_BITS;       // q * P
    localparam int T_W        = E_W + 2;            // trial term

    // one finished vector: the three sums
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic        [SQ_W-1:0]  sa;
        logic        [SQ_W-1:0]  sb;
    } t_acc;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: src/csim_front.sv
// ----------------------------------------------------------------------------
// csim_front
// Per-beat MAC: running dot product and sums of squares with saturation.
// On the last pair the finished sums go to the queue and the sums clear.
// ----------------------------------------------------------------------------
module csim_front #(
    parameter int ELEM_WIDTH = csim_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_b,
    input  logic                          i_last_element,
    output logic                          o_push,
    output csim_pkg::t_acc                o_push_data
);
    import csim_pkg::*;

    localparam int PW  = 2 * ELEM_WIDTH;
    localparam int DSW = ((PW > DOT_W) ? PW : DOT_W) + 1;
    localparam int SSW = ((PW > SQ_W) ? PW : SQ_W) + 1;
    localparam logic signed [DSW-1:0] DMAX = (DSW'(1) <<< (DOT_W - 1)) - DSW'(1);
    localparam logic signed [DSW-1:0] DMIN = -(DSW'(1) <<< (DOT_W - 1));
    localparam logic [SSW-1:0] SMAX = (SSW'(1) << SQ_W) - SSW'(1);

    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [SQ_W-1:0] r_sa, n_sa, r_sb, n_sb;

    logic signed [PW-1:0] prod_ab, prod_aa, prod_bb;
    logic signed [DSW-1:0] dsum;
    logic [SSW-1:0] sum_a, sum_b;

    // products and wide sums
    assign prod_ab = i_elem_a * i_elem_b;
    assign prod_aa = i_elem_a * i_elem_a;
    assign prod_bb = i_elem_b * i_elem_b;
    assign dsum  = DSW'(r_dot) + DSW'(prod_ab);
    assign sum_a = SSW'(r_sa) + SSW'(unsigned'(prod_aa));
    assign sum_b = SSW'(r_sb) + SSW'(unsigned'(prod_bb));

    // clamp to accumulator range
    always_comb begin
        if (dsum > DMAX) begin
            n_dot = DOT_W'(DMAX);
        end else if (dsum < DMIN) begin
            n_dot = DOT_W'(DMIN);
        end else begin
            n_dot = DOT_W'(dsum);
        end
        n_sa = (sum_a > SMAX) ? SQ_W'(SMAX) : SQ_W'(sum_a);
        n_sb = (sum_b > SMAX) ? SQ_W'(SMAX) : SQ_W'(sum_b);
    end

    assign o_push           = i_accept & i_last_element;
    assign o_push_data.dot  = n_dot;
    assign o_push_data.sa   = n_sa;
    assign o_push_data.sb   = n_sb;

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
        end else if (i_accept) begin
            if (i_last_element) begin
                r_dot <= '0;
                r_sa  <= '0;
                r_sb  <= '0;
            end else begin
                r_dot <= n_dot;
                r_sa  <= n_sa;
                r_sb  <= n_sb;
            end
        end
    end

endmodule

// File: src/csim_fifo.sv
// ----------------------------------------------------------------------------
// csim_fifo
// Short queue of finished sums between the MAC front and the root back end.
// ----------------------------------------------------------------------------
module csim_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  csim_pkg::t_acc       i_push_data,
    input  logic                 i_pop,
    output csim_pkg::t_acc       o_pop_data,
    output csim_pkg::t_fifo_stat o_stat
);
    import csim_pkg::*;
    `include "cosine_similarity_engine_macros.svh"

    t_acc             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `CSIM_ASSERT(a_no_push_full, i_push |-> !o_stat.full, "push into full queue")
    `CSIM_ASSERT(a_no_pop_empty, i_pop |-> !o_stat.empty, "pop from empty queue")
    `CSIM_ASSERT_ALWAYS(a_count_range, !i_rst_n || (r_count <= CNT_W'(FIFO_DEPTH)), "queue count overflow")

endmodule

// File: src/csim_back.sv
// ----------------------------------------------------------------------------
// csim_back
// Root and divide back end. Forms P = sumA*sumB and D = dot*dot on one
// shared 21x21 multiplier, then finds the largest q with q*q*P <= D*2^30
// one bit at a time by shift and subtract, and registers the result.
// ----------------------------------------------------------------------------
module csim_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  csim_pkg::t_acc                   i_pop_data,
    input  csim_pkg::t_fifo_stat             i_stat,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [csim_pkg::RES_W-1:0] o_similarity,
    output logic                             o_zero_magnitude
);
    import csim_pkg::*;
    `include "cosine_similarity_engine_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_TRY,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;

    logic [MAG_W-1:0]  r_sa, r_sb, r_dmag;
    logic              r_neg, r_zero;
    logic [2:0]        r_step;
    logic [PP_W-1:0]   r_pp;
    logic [1:0]        r_pp_sh;
    logic              r_pp_sel, r_pp_vld;
    logic [P_W-1:0]    r_p;
    logic [R_W-1:0]    r_r;
    logic [E_W-1:0]    r_e;
    logic [M_W-1:0]    r_m;
    logic [T_W-1:0]    r_t;
    logic [3:0]        r_bit;
    logic [Q_BITS-1:0] r_q;
    logic              r_out_valid, r_out_zero;
    logic signed [RES_W-1:0] r_out_sim;

    logic              start_zero;
    logic [MAG_W-1:0]  mul_x, mul_y, pop_dmag;
    logic [MUL_HALF-1:0] half_x, half_y;
    logic [PP_W-1:0]   pp;
    logic [ACC_W-1:0]  pp_shifted, acc_p_sum, acc_r_sum;
    logic [T_W-1:0]    trial;
    logic              fits;
    logic [Q_BITS-1:0] q_capped;
    logic signed [RES_W-1:0] res_val;
    logic              out_free;

    // pop when idle and an item waits
    assign o_pop      = (r_state == S_IDLE) && !i_stat.empty;
    assign start_zero = (i_pop_data.sa == '0) || (i_pop_data.sb == '0);
    assign pop_dmag   = i_pop_data.dot[DOT_W-1] ? MAG_W'(-i_pop_data.dot)
                                                : MAG_W'(i_pop_data.dot);

    // shared multiplier: step[2] picks the product, step[1:0] the halves
    assign mul_x  = r_step[2] ? r_dmag : r_sa;
    assign mul_y  = r_step[2] ? r_dmag : r_sb;
    assign half_x = r_step[1] ? MUL_HALF'(mul_x[MAG_W-1:MUL_HALF]) : mul_x[MUL_HALF-1:0];
    assign half_y = r_step[0] ? MUL_HALF'(mul_y[MAG_W-1:MUL_HALF]) : mul_y[MUL_HALF-1:0];
    assign pp     = half_x * half_y;

    // align registered partial product
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = ACC_W'(r_pp);
            2'd1:    pp_shifted = ACC_W'(r_pp) << MUL_HALF;
            default: pp_shifted = ACC_W'(r_pp) << (2 * MUL_HALF);
        endcase
    end
    assign acc_p_sum = ACC_W'(r_p) + pp_shifted;
    assign acc_r_sum = r_r + pp_shifted;

    // root search: trial term and its fit against the remainder
    assign trial = (T_W'(r_m) << ({1'b0, r_bit} + 5'd1)) + (T_W'(r_p) << {r_bit, 1'b0});
    assign fits  = (r_t <= T_W'(r_e));

    // cap and sign
    always_comb begin
        if (r_neg) begin
            q_capped = (r_q > CAP_NEG) ? CAP_NEG : r_q;
            res_val  = RES_W'(-q_capped);
        end else begin
            q_capped = (r_q > CAP_POS) ? CAP_POS : r_q;
            res_val  = RES_W'(q_capped);
        end
    end

    assign out_free = !r_out_valid || i_ready;

    // sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_sa   <= MAG_W'(i_pop_data.sa);
                        r_sb   <= MAG_W'(i_pop_data.sb);
                        r_dmag <= pop_dmag;
                        r_neg  <= i_pop_data.dot[DOT_W-1];
                        r_zero <= start_zero;
                        r_step <= '0;
                        r_p    <= '0;
                        r_r    <= '0;
                        r_q    <= '0;
                        r_state <= start_zero ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_pp     <= pp;
                    r_pp_sh  <= 2'(r_step[1]) + 2'(r_step[0]);
                    r_pp_sel <= r_step[2];
                    r_pp_vld <= 1'b1;
                    if (r_pp_vld) begin
                        if (r_pp_sel) begin
                            r_r <= acc_r_sum;
                        end else begin
                            r_p <= P_W'(acc_p_sum);
                        end
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last partial product lands in D; start the search
                    r_pp_vld <= 1'b0;
                    r_e      <= E_W'(acc_r_sum) << ROOT_SHIFT;
                    r_r      <= acc_r_sum;
                    r_m      <= '0;
                    r_bit    <= 4'(Q_BITS - 1);
                    r_state  <= S_TRY;
                end
                S_TRY: begin
                    r_t     <= trial;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (fits) begin
                        r_e        <= r_e - E_W'(r_t);
                        r_m        <= r_m + (M_W'(r_p) << r_bit);
                        r_q[r_bit] <= 1'b1;
                    end
                    r_bit   <= r_bit - 4'd1;
                    r_state <= (r_bit == '0) ? S_DONE : S_TRY;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_zero  <= r_zero;
                        r_out_sim   <= r_zero ? '0 : res_val;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_similarity     = r_out_sim;
    assign o_zero_magnitude = r_out_zero;

    `CSIM_ASSERT(a_pop_idle, o_pop |-> (r_state == S_IDLE), "pop outside idle")
    `CSIM_ASSERT(a_zero_sim, (o_valid && o_zero_magnitude) |-> (o_similarity == '0),
                 "zero magnitude with nonzero similarity")
    `CSIM_ASSERT(a_load_free, (r_state == S_DONE && out_free) |=> o_valid,
                 "finished result not registered")

endmodule

// File: src/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two Q1.15 vectors, one element pair a beat.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   input    | in        | i_valid / o_ready  | i_elem_a, i_elem_b,
//            |           |                    | i_last_element
//   output   | out       | o_valid / i_ready  | o_similarity, o_zero_magnitude
//
// The MAC front takes one pair per cycle while o_ready is high. The back end
// takes each vector's sums from the queue, forms the products on the shared
// 21x21 multiplier, runs the 16-bit root search, then loads the output register.
// A zero-magnitude vector skips the multiplier and root search in the back end.
// Reset is synchronous and active low; the sums clear, no clearing pass.
// o_ready drops only on a last pair while the two-entry queue is full.
// ----------------------------------------------------------------------------
module cosine_similarity_engine #(
    parameter int ELEM_WIDTH = csim_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [ELEM_WIDTH-1:0]      i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]      i_elem_b,
    input  logic                              i_last_element,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [csim_pkg::RES_W-1:0] o_similarity,
    output logic                              o_zero_magnitude
);
    import csim_pkg::*;

    logic       accept, push, pop;
    t_acc       push_data, pop_data;
    t_fifo_stat stat;

    assign o_ready = !(stat.full && i_last_element);
    assign accept  = i_valid && o_ready;

    csim_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_last_element (i_last_element),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    csim_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (stat)
    );

    csim_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_data       (pop_data),
        .i_stat           (stat),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_similarity     (o_similarity),
        .o_zero_magnitude (o_zero_magnitude)
    );

endmodule
